// ===== rtl/core/bokl_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered key list package
// Sizes, operation codes, sequencer states and shared types of the key list.
// ----------------------------------------------------------------------------
package bokl_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int OP_W     = 3;
  localparam int OUT_CNT_W = 7;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_W    = 1 + KEY_W + OUT_CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_ORDERED   = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_POP_TAIL  = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_QUERY     = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_OI_LOOP,
    ST_OI_LAST,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [KEY_W-1:0] data;
  } ram_wr_t;

  // Map a list position to a ring slot relative to the head slot.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bokl_key_ram.sv =====
// ----------------------------------------------------------------------------
// Key store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bokl_key_ram (
  input  logic                            clk,
  input  bokl_pkg::ram_wr_t               wr,
  input  logic [bokl_pkg::PTR_W-1:0]      rd_addr,
  output logic [bokl_pkg::KEY_W-1:0]      rd_data
);

  logic [bokl_pkg::KEY_W-1:0] mem [bokl_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bounded_ordered_key_list_top.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered key list
// Ring-buffer key list with head/tail push and pop, ordered insert, remove
// by key and query, run by a small sequencer over one store port pair.
// ----------------------------------------------------------------------------
// Input channel: s_axis_tuser carries the operation, s_axis_tdata the key.
// One word is taken only while the sequencer is idle; each input word gives
// exactly one output word (ok, removed key, new count) on the m_axis channel.
// Steps per word: refused operations, the unused code, pushes and an ordered
// insert into an empty list go straight from idle to the output; pops read
// the end key first; ordered insert otherwise steps through every held key,
// then writes the last one at the tail; remove key and query scan from the
// head, query stops at a match, remove shifts the later keys toward the head.
// The long cases step once a cycle through the store: one read and at most one
// write per cycle; ordered insert uses a signed compare, remove and query equality.
// The result sits in an output register; while the receiver stalls the
// input side stays open until the next result is ready, then the sequencer
// holds that result until the output register frees.
// Reset (rst, synchronous) empties the list and drops any pending result;
// the store contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_ordered_key_list_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // key[31:0]
  input  logic [bokl_pkg::OP_W-1:0]     s_axis_tuser,   // operation[2:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bokl_pkg::OUT_W-1:0]    m_axis_tdata    // ok[0], removed_key[32:1],
                                                        // entry_count[39:33]
);

  bokl_pkg::state_t                 state, state_next;
  logic [bokl_pkg::PTR_W-1:0]       head, head_next;
  logic [bokl_pkg::CNT_W-1:0]       count, count_next;
  logic [bokl_pkg::CNT_W-1:0]       scan, scan_next;
  logic                             found, found_next;
  logic                             is_query, is_query_next;
  logic                             pop_head, pop_head_next;
  logic [bokl_pkg::KEY_W-1:0]       key_r, key_r_next;
  logic                             res_ok, res_ok_next;
  logic [bokl_pkg::KEY_W-1:0]       res_removed, res_removed_next;

  logic                             out_ok;
  logic [bokl_pkg::KEY_W-1:0]       out_removed;
  logic [bokl_pkg::OUT_CNT_W-1:0]   out_count;
  logic                             out_load;

  bokl_pkg::ram_wr_t                wr;
  logic [bokl_pkg::PTR_W-1:0]       rd_addr;
  logic [bokl_pkg::KEY_W-1:0]       rd_data;

  logic                             full, empty, last;
  logic [bokl_pkg::PTR_W-1:0]       head_dec, head_inc;
  logic [bokl_pkg::CNT_W-1:0]       one;

  bokl_key_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign one      = bokl_pkg::CNT_W'(1);
  assign full     = count >= bokl_pkg::CNT_W'(bokl_pkg::CAPACITY);
  assign empty    = count == '0;
  assign last     = scan == (count - one);
  assign head_dec = (head == '0) ? bokl_pkg::PTR_W'(bokl_pkg::CAPACITY - 1) : head - 1'b1;
  assign head_inc = (head == bokl_pkg::PTR_W'(bokl_pkg::CAPACITY - 1)) ? '0 : head + 1'b1;

  assign s_axis_tready = (state == bokl_pkg::ST_IDLE);
  assign out_load      = (state == bokl_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign m_axis_tdata  = {out_count, out_removed, out_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bokl_pkg::ST_IDLE;
      head          <= '0;
      count         <= '0;
      found         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      found <= found_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan        <= scan_next;
    is_query    <= is_query_next;
    pop_head    <= pop_head_next;
    key_r       <= key_r_next;
    res_ok      <= res_ok_next;
    res_removed <= res_removed_next;
    if (out_load) begin
      out_ok      <= res_ok;
      out_removed <= res_removed;
      out_count   <= bokl_pkg::OUT_CNT_W'(count);
    end
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    scan_next        = scan;
    found_next       = found;
    is_query_next    = is_query;
    pop_head_next    = pop_head;
    key_r_next       = key_r;
    res_ok_next      = res_ok;
    res_removed_next = res_removed;
    wr               = '0;
    rd_addr          = bokl_pkg::slot(head, scan + one);

    unique case (state)
      bokl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_r_next       = s_axis_tdata;
          res_ok_next      = 1'b0;
          res_removed_next = '0;
          found_next       = 1'b0;
          state_next       = bokl_pkg::ST_OUT;
          case (bokl_pkg::op_t'(s_axis_tuser))
            bokl_pkg::OP_PUSH_HEAD: begin
              if (!full) begin
                wr          = '{en: 1'b1, addr: head_dec, data: s_axis_tdata};
                head_next   = head_dec;
                count_next  = count + one;
                res_ok_next = 1'b1;
              end
            end
            bokl_pkg::OP_PUSH_TAIL: begin
              if (!full) begin
                wr = '{en: 1'b1, addr: bokl_pkg::slot(head, count), data: s_axis_tdata};
                count_next  = count + one;
                res_ok_next = 1'b1;
              end
            end
            bokl_pkg::OP_ORDERED: begin
              if (!full) begin
                if (empty) begin
                  wr          = '{en: 1'b1, addr: head, data: s_axis_tdata};
                  count_next  = count + one;
                  res_ok_next = 1'b1;
                end else begin
                  rd_addr    = head;
                  scan_next  = '0;
                  state_next = bokl_pkg::ST_OI_LOOP;
                end
              end
            end
            bokl_pkg::OP_POP_HEAD, bokl_pkg::OP_POP_TAIL: begin
              if (!empty) begin
                pop_head_next = (bokl_pkg::op_t'(s_axis_tuser) == bokl_pkg::OP_POP_HEAD);
                rd_addr = (bokl_pkg::op_t'(s_axis_tuser) == bokl_pkg::OP_POP_HEAD) ?
                          head : bokl_pkg::slot(head, count - one);
                state_next = bokl_pkg::ST_POP;
              end
            end
            bokl_pkg::OP_REMOVE, bokl_pkg::OP_QUERY: begin
              if (!empty) begin
                is_query_next = (bokl_pkg::op_t'(s_axis_tuser) == bokl_pkg::OP_QUERY);
                rd_addr       = head;
                scan_next     = '0;
                state_next    = bokl_pkg::ST_SCAN;
              end
            end
            default: begin
              res_ok_next = 1'b0;
            end
          endcase
        end
      end

      bokl_pkg::ST_POP: begin
        res_removed_next = rd_data;
        res_ok_next      = 1'b1;
        count_next       = count - one;
        if (pop_head) begin
          head_next = head_inc;
        end
        state_next = bokl_pkg::ST_OUT;
      end

      // Carry the displaced key toward the tail once the slot is found.
      bokl_pkg::ST_OI_LOOP: begin
        scan_next = scan + one;
        if (found || !($signed(rd_data) < $signed(key_r))) begin
          wr         = '{en: 1'b1, addr: bokl_pkg::slot(head, scan), data: key_r};
          key_r_next = rd_data;
          found_next = 1'b1;
        end
        if (last) begin
          state_next = bokl_pkg::ST_OI_LAST;
        end
      end

      bokl_pkg::ST_OI_LAST: begin
        wr          = '{en: 1'b1, addr: bokl_pkg::slot(head, count), data: key_r};
        count_next  = count + one;
        res_ok_next = 1'b1;
        found_next  = 1'b0;
        state_next  = bokl_pkg::ST_OUT;
      end

      bokl_pkg::ST_SCAN: begin
        scan_next = scan + one;
        if (found) begin
          wr = '{en: 1'b1, addr: bokl_pkg::slot(head, scan - one), data: rd_data};
          if (last) begin
            count_next  = count - one;
            res_ok_next = 1'b1;
            found_next  = 1'b0;
            state_next  = bokl_pkg::ST_OUT;
          end
        end else if (rd_data == key_r) begin
          if (is_query) begin
            res_ok_next = 1'b1;
            state_next  = bokl_pkg::ST_OUT;
          end else if (last) begin
            count_next  = count - one;
            res_ok_next = 1'b1;
            state_next  = bokl_pkg::ST_OUT;
          end else begin
            found_next = 1'b1;
          end
        end else if (last) begin
          res_ok_next = 1'b0;
          state_next  = bokl_pkg::ST_OUT;
        end
      end

      bokl_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = bokl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bokl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bokl_checker.sv =====
// ----------------------------------------------------------------------------
// Key list port checker
// Port-level checks on the key list channels, bound to the top level.
// ----------------------------------------------------------------------------
module bokl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [bokl_pkg::OUT_W-1:0]  m_axis_tdata
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Drop ready for the cycle after a word is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an operation is in progress");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] || (m_axis_tdata[32:1] == '0)))
    else $error("removed key nonzero on a failed operation");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((bokl_pkg::CAPACITY > 127) ||
                       (int'(m_axis_tdata[39:33]) <= bokl_pkg::CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind bounded_ordered_key_list_top bokl_checker u_bokl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_bounded_ordered_key_list_top.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered key list testbench
// Streams list operations into the block: a short directed run over empty,
// duplicate and extreme-key cases, then random phases that fill the list
// past capacity, drain it past empty and mix operations. A queue-based
// predictor computes each result word and the monitor checks it field by
// field. Both channels idle in random bursts, with a quiet tail at the end.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_key_list_top;
  import bokl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int CALM_TAIL    = 60;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [31:0]     key;
  } list_cmd_t;

  typedef struct {
    logic        ok;
    logic [31:0] removed_key;
    logic [6:0]  entry_count;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;   // key[31:0]
  logic [OP_W-1:0]    s_axis_tuser = '0;   // operation[2:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;        // ok[0], removed_key[32:1], entry_count[39:33]

  list_cmd_t    pending_ops[$];
  list_result_t outstanding_results[$];
  logic [31:0]  held_keys[$];
  logic [31:0]  key_pool[10];

  logic in_taken = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   send_idle_pct = 15;
  int   recv_idle_pct = 15;
  int   cycles = 0;
  int   errors = 0;
  int   words_checked = 0;
  int   op_tally[8] = '{default: 0};
  int   full_refusals = 0;
  int   empty_refusals = 0;
  int   peak_count = 0;

  bounded_ordered_key_list_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void apply_list_op(input logic [OP_W-1:0] op, input logic [31:0] key,
                                        output list_result_t r);
    int  pos;
    logic full;
    logic empty;
    full  = held_keys.size() >= CAPACITY;
    empty = held_keys.size() == 0;
    r.ok = 1'b0;
    r.removed_key = '0;
    op_tally[op]++;
    case (op)
      OP_PUSH_HEAD: if (!full) begin
        held_keys.push_front(key);
        r.ok = 1'b1;
      end
      OP_PUSH_TAIL: if (!full) begin
        held_keys.push_back(key);
        r.ok = 1'b1;
      end
      OP_ORDERED: if (!full) begin
        pos = 0;
        while (pos < held_keys.size() && $signed(held_keys[pos]) < $signed(key)) pos++;
        held_keys.insert(pos, key);
        r.ok = 1'b1;
      end
      OP_POP_HEAD: if (!empty) begin
        r.removed_key = held_keys.pop_front();
        r.ok = 1'b1;
      end
      OP_POP_TAIL: if (!empty) begin
        r.removed_key = held_keys.pop_back();
        r.ok = 1'b1;
      end
      OP_REMOVE, OP_QUERY: begin
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] != key) pos++;
        if (pos < held_keys.size()) begin
          r.ok = 1'b1;
          if (op == OP_REMOVE) held_keys.delete(pos);
        end
      end
      default: ;
    endcase
    if (full && (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL || op == OP_ORDERED))
      full_refusals++;
    if (empty && (op == OP_POP_HEAD || op == OP_POP_TAIL || op == OP_REMOVE))
      empty_refusals++;
    if (held_keys.size() > peak_count) peak_count = held_keys.size();
    r.entry_count = 7'(held_keys.size());
  endfunction

  // Input driver: hold a word until taken, then advance or idle.
  always @(negedge clk) begin : drive_in
    logic            nxt_valid;
    logic [31:0]     nxt_key;
    logic [OP_W-1:0] nxt_op;
    list_cmd_t       cmd;
    nxt_valid = s_axis_tvalid;
    nxt_key   = s_axis_tdata;
    nxt_op    = s_axis_tuser;
    if ($urandom_range(0, 199) == 0) begin
      case ($urandom_range(0, 3))
        0: send_idle_pct = 0;
        1: send_idle_pct = 4;
        2: send_idle_pct = 15;
        default: send_idle_pct = 35;
      endcase
    end
    if (!rst && !(s_axis_tvalid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_ops.size() > 0) begin
        if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 13);
        end else begin
          cmd       = pending_ops.pop_front();
          nxt_valid = 1'b1;
          nxt_key   = cmd.key;
          nxt_op    = cmd.op;
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_key;
    s_axis_tuser  <= nxt_op;
  end

  // Output receiver: stall in bursts until the quiet tail.
  always @(negedge clk) begin : drive_out
    logic nxt_ready;
    nxt_ready = 1'b1;
    if ($urandom_range(0, 199) == 0) begin
      case ($urandom_range(0, 3))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 4;
        2: recv_idle_pct = 15;
        default: recv_idle_pct = 35;
      endcase
    end
    if (rst) begin
      nxt_ready = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      nxt_ready = 1'b0;
    end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap  = $urandom_range(0, 13);
      nxt_ready = 1'b0;
    end
    m_axis_tready <= nxt_ready;
  end

  always @(posedge clk) begin : monitor
    list_result_t want;
    logic         got_ok;
    logic [31:0]  got_removed;
    logic [6:0]   got_count;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        apply_list_op(s_axis_tuser, s_axis_tdata, want);
        outstanding_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_ok      = m_axis_tdata[0];
        got_removed = m_axis_tdata[32:1];
        got_count   = m_axis_tdata[39:33];
        if (outstanding_results.size() == 0) begin
          $display("%0t: result word with nothing outstanding, expected none, got %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = outstanding_results.pop_front();
          words_checked++;
          if (got_ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok, got_ok);
            errors++;
          end
          if (got_removed !== want.removed_key) begin
            $display("%0t: removed_key mismatch, expected %h, got %h",
                     $time, want.removed_key, got_removed);
            errors++;
          end
          if (got_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, got %0d",
                     $time, want.entry_count, got_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_bounded_ordered_key_list_top failed");
      $finish;
    end
  end

  task automatic add_op(input logic [OP_W-1:0] op, input logic [31:0] key);
    list_cmd_t c;
    c.op  = op;
    c.key = key;
    pending_ops.push_back(c);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, 9)];
    return $urandom;
  endfunction

  // Bias toward inserts by insert_pct; two percent are the unused code, the rest pops, removals and queries.
  task automatic add_random(input int count, input int insert_pct);
    int r;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < insert_pct) op = OP_W'($urandom_range(0, 2));
      else op = OP_W'($urandom_range(3, 6));
      add_op(op, pick_key());
    end
  endtask

  initial begin
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = KEY_MIN;
    key_pool[3] = KEY_MAX;
    key_pool[4] = 32'd1;
    for (int i = 5; i < 10; i++) key_pool[i] = $urandom;

    // empty list: refused removals, negative query, unused code, ordered insert into empty
    add_op(OP_QUERY, 32'd0);
    add_op(OP_POP_HEAD, 32'hFFFF_FFFF);
    add_op(OP_POP_TAIL, 32'd0);
    add_op(OP_REMOVE, 32'd0);
    add_op(OP_UNUSED, 32'hFFFF_FFFF);
    add_op(OP_ORDERED, 32'd42);
    add_op(OP_POP_HEAD, 32'd0);
    // extremes at both ends
    add_op(OP_PUSH_TAIL, KEY_MAX);
    add_op(OP_PUSH_HEAD, KEY_MIN);
    add_op(OP_PUSH_TAIL, 32'd0);
    add_op(OP_PUSH_HEAD, 32'hFFFF_FFFF);
    add_op(OP_POP_HEAD, 32'd0);
    add_op(OP_POP_TAIL, 32'd0);
    // ordered insert with duplicates and extremes, then queries, removals and pops
    add_op(OP_ORDERED, 32'd5);
    add_op(OP_ORDERED, 32'd5);
    add_op(OP_ORDERED, KEY_MIN);
    add_op(OP_ORDERED, KEY_MAX);
    add_op(OP_QUERY, 32'd5);
    add_op(OP_QUERY, 32'd6);
    add_op(OP_REMOVE, 32'd7);
    add_op(OP_REMOVE, 32'd5);
    add_op(OP_REMOVE, KEY_MIN);
    add_op(OP_UNUSED, 32'd5);
    add_op(OP_POP_TAIL, 32'd0);
    add_op(OP_POP_HEAD, 32'd0);

    // fill past capacity, drain past empty, mix, then again
    add_random(90, 90);
    add_random(90, 8);
    add_random(250, 50);
    add_random(80, 85);
    add_random(90, 10);

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_ops.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (outstanding_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words checked: push head %0d, push tail %0d, ordered %0d, pop head %0d,",
             words_checked, op_tally[OP_PUSH_HEAD], op_tally[OP_PUSH_TAIL],
             op_tally[OP_ORDERED], op_tally[OP_POP_HEAD]);
    $display("  pop tail %0d, remove %0d, query %0d, unused %0d; peak %0d keys, %0d full and %0d empty refusals",
             op_tally[OP_POP_TAIL], op_tally[OP_REMOVE], op_tally[OP_QUERY],
             op_tally[OP_UNUSED], peak_count, full_refusals, empty_refusals);
    if (errors == 0 && outstanding_results.size() == 0) begin
      $display("tb_bounded_ordered_key_list_top passed");
    end else begin
      $display("tb_bounded_ordered_key_list_top failed");
    end
    $finish;
  end

endmodule

// ===== bounded_ordered_key_list_top.f =====
rtl/core/bokl_pkg.sv
rtl/core/bokl_key_ram.sv
rtl/core/bounded_ordered_key_list_top.sv
rtl/core/bokl_checker.sv
dv/tb_bounded_ordered_key_list_top.sv
